[design/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros for the signed integer to decimal text converter.
// Expects clk and rst_n in scope at the point of use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sitda_pkg.sv]
// Shared constants for the signed integer to decimal text converter.
// No dependencies.
package sitda_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int CHAR_W         = 6;
  // Binary bits folded into the BCD register per cycle.
  localparam int BITS_PER_STEP  = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // Decimal digits that cover any unsigned value of the given width.
  function automatic int dec_digits(input int width);
    return (width * 30103) / 100000 + 1;
  endfunction

endpackage

[design/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII text, one character per output beat.
// Depends on sitda_pkg and signed_int_to_decimal_ascii_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_value) takes one two's complement
//   integer of DATA_WIDTH bits. The output channel (out_valid/out_ready)
//   delivers its decimal text, most significant first: a '-' for negative
//   values, then the digits, with out_last set on the final digit. Zero
//   gives the single character '0'; the most negative value is handled.
//   Sequence: after the input beat, the BCD converter folds four binary
//   bits per cycle until all DATA_WIDTH bits are in, then the ST_FIND
//   state locates the leading digit, then one character goes out per
//   cycle while the receiver takes them. in_ready is high only between
//   numbers; the next number may enter while the last character still
//   waits in the output register.
//   When out_ready is low the output register holds its beat and the
//   emit sequencer waits. Reset (synchronous, rst_n low) drops any number
//   in flight and empties the output register.
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = sitda_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sitda_pkg::CHAR_W-1:0] out_character,
  output logic                         out_last
);

  localparam int SHIFT = sitda_pkg::BITS_PER_STEP;
  localparam int STEPS = (DATA_WIDTH + SHIFT - 1) / SHIFT;
  localparam int PAD_W = STEPS * SHIFT;
  localparam int NDIG  = sitda_pkg::dec_digits(DATA_WIDTH);
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(STEPS);
  localparam int DIG_W = $clog2(NDIG);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [PAD_W-1:0]             bin_r, bin_nxt;
  logic [BCD_W-1:0]             bcd_r, bcd_nxt;
  logic                         neg_r, neg_nxt;
  logic                         sign_pend_r, sign_pend_nxt;
  logic [DIG_W-1:0]             dig_r, dig_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [DATA_WIDTH-1:0]        in_mag;
  logic [BCD_W+PAD_W-1:0]       dab_work;
  logic [DIG_W-1:0]             lead_idx;
  logic [3:0]                   cur_nib;
  logic                         out_load;

  // Magnitude as unsigned; the most negative value maps onto itself.
  assign in_mag = in_value[DATA_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  // Shift-add-3 unit: fold SHIFT binary bits into the BCD digits.
  always_comb begin
    dab_work = {bcd_r, bin_r};
    for (int s = 0; s < SHIFT; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (dab_work[PAD_W + 4*k +: 4] >= 4'd5) begin
          dab_work[PAD_W + 4*k +: 4] = dab_work[PAD_W + 4*k +: 4] + 4'd3;
        end
      end
      dab_work = {dab_work[BCD_W+PAD_W-2:0], 1'b0};
    end
  end

  // Highest nonzero digit; zero keeps the units digit.
  always_comb begin
    lead_idx = '0;
    for (int k = 1; k < NDIG; k++) begin
      if (bcd_r[4*k +: 4] != 4'd0) begin
        lead_idx = DIG_W'(k);
      end
    end
  end

  assign cur_nib  = bcd_r[dig_r*4 +: 4];
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = PAD_W'(in_mag);
          bcd_nxt   = '0;
          neg_nxt   = in_value[DATA_WIDTH-1];
          cnt_nxt   = CNT_W'(STEPS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = dab_work[PAD_W +: BCD_W];
        bin_nxt = dab_work[PAD_W-1:0];
        if (cnt_r == '0) begin
          state_nxt = ST_FIND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIND: begin
        dig_nxt       = lead_idx;
        sign_pend_nxt = neg_r;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = sitda_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = sitda_pkg::CHAR_ZERO + {2'b00, cur_nib};
            out_last_nxt = (dig_r == '0);
            if (dig_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              dig_nxt = dig_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    dig_r       <= dig_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`include "signed_int_to_decimal_ascii_macros.svh"

  `SITDA_ASSERT_NEXT(a_accept_starts_conv, in_valid && in_ready, state_r == ST_CONV,
                     "accepted beat did not start conversion")
  `SITDA_ASSERT_NOW(a_minus_not_last, out_valid && out_character == sitda_pkg::CHAR_MINUS,
                    !out_last, "minus sign flagged as last")
  `SITDA_ASSERT_NOW(a_char_range, out_valid,
                    out_character == sitda_pkg::CHAR_MINUS ||
                    (out_character >= sitda_pkg::CHAR_ZERO &&
                     out_character <= sitda_pkg::CHAR_ZERO + 6'd9),
                    "character outside sign and digits")
  `SITDA_ASSERT_NEXT(a_find_to_emit, state_r == ST_FIND,
                     state_r == ST_EMIT && sign_pend_r == neg_r,
                     "leading digit search did not enter emit")
  `SITDA_ASSERT_NOW(a_sign_first, state_r == ST_EMIT && sign_pend_r, neg_r,
                    "sign pending for a nonnegative number")

endmodule
